### hw/rtl/fra_pkg.sv
// ---------------------------------------------------------------------------
// fra_pkg: shared types and constants for the frame rate meter
// Word type for timestamps and intervals, register reset value.
// ---------------------------------------------------------------------------
package fra_pkg;

   localparam int WORD_W = 32;

   typedef logic [WORD_W-1:0] word_type;

   // reset value of the ticks per second register
   localparam word_type TPS_RESET = 32'd1000;

   // all-ones word, saturation limit of the frame count
   localparam word_type WORD_MAX = {WORD_W{1'b1}};

endpackage

### hw/rtl/fra_cell.sv
// ---------------------------------------------------------------------------
// fra_cell: one stage of the interval history chain
// Holds one stored interval and hands it to the next cell on a shift.
// ---------------------------------------------------------------------------
module fra_cell (
   input  logic              clock,
   input  logic              shift_en,
   input  fra_pkg::word_type d_in,
   output fra_pkg::word_type d_out
);

   fra_pkg::word_type value_ff;

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      if (shift_en) begin
         value_ff <= d_in;
      end
   end

   assign d_out = value_ff;

endmodule

### hw/rtl/fra_divider.sv
// ---------------------------------------------------------------------------
// fra_divider: serial restoring divider for the mean interval
// One quotient bit per cycle; a zero divisor yields a zero quotient.
// ---------------------------------------------------------------------------
module fra_divider #(
   parameter int SW = 38,
   parameter int CW = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SW-1:0]     dividend,
   input  logic [CW-1:0]     divisor,
   output logic              done,
   output fra_pkg::word_type quotient
);

   localparam int KW = $clog2(SW);
   localparam logic [KW-1:0] LAST = KW'(SW - 1);

   logic          busy_ff;
   logic          done_ff;
   logic          zero_ff;
   logic [KW-1:0] cnt_ff;
   logic [SW-1:0] qd_ff;
   logic [CW-1:0] rem_ff;
   logic [CW-1:0] dvs_ff;

   logic [CW:0]   rem_shift;
   logic          q_bit;
   logic [CW:0]   rem_diff;

   // one trial subtraction step
   always_comb begin
      rem_shift = {rem_ff, qd_ff[SW-1]};
      rem_diff  = rem_shift - {1'b0, dvs_ff};
      q_bit     = (rem_shift >= {1'b0, dvs_ff});
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath: quotient bits shift in as dividend bits shift out
   always_ff @(posedge clock) begin
      if (start) begin
         qd_ff   <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
         zero_ff <= (divisor == '0);
      end else if (busy_ff) begin
         qd_ff  <= {qd_ff[SW-2:0], q_bit};
         rem_ff <= q_bit ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = zero_ff ? '0 : qd_ff[fra_pkg::WORD_W-1:0];

endmodule

### hw/rtl/frame_rate_meter_unit.sv
// ---------------------------------------------------------------------------
// frame_rate_meter_unit: frame interval averager and frame rate counter
//
// Each req word carries one frame timestamp (req_now) in counter ticks.
// The interval since the previous frame is checked against the running
// mean; if within one second of ticks it shifts into a chain of SAMPLES
// history cells, the oldest dropping out of the far end once full.
// Frames and interval ticks are counted; when the tick sum passes
// csr_ticks_per_second the frame count latches as the frame rate.
// Each frame gives one rsp word: mean interval, latched rate, update flag.
// The frame passes S_CALC and S_DIV, where the one-bit-per-cycle divider
// forms the mean over SW = 32 + clog2(SAMPLES) bits, before rsp_valid.
// One frame is processed at a time; req_stall is high while it is in work.
// A finished word waits in the output register while the next frame is
// taken; if rsp_stall keeps that register full, the next result holds.
// The csr port is always ready and should be written only when idle.
// Reset (synchronous) clears all counters, the mean and the last
// timestamp and restores ticks_per_second to 1000; history cells start
// empty by count, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module frame_rate_meter_unit #(
   parameter int SAMPLES = 64
) (
   input  logic              clock,
   input  logic              reset,
   // frame timestamps
   input  logic              req_valid,
   output logic              req_stall,
   input  fra_pkg::word_type req_now,
   // results
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fra_pkg::word_type rsp_average_interval,
   output fra_pkg::word_type rsp_frame_rate,
   output logic              rsp_rate_updated,
   // configuration
   input  logic              csr_valid,
   output logic              csr_ready,
   input  fra_pkg::word_type csr_ticks_per_second
);

   localparam int CW = $clog2(SAMPLES + 1);
   localparam int SW = fra_pkg::WORD_W + $clog2(SAMPLES);
   localparam logic [CW-1:0] FULL = CW'(SAMPLES);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CALC = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_HOLD = 2'd3;

   logic [1:0]        state_ff, state_in;
   fra_pkg::word_type tps_ff;
   fra_pkg::word_type now_ff;
   fra_pkg::word_type last_ff;
   logic [SW-1:0]     sum_ff, sum_in;
   logic [CW-1:0]     count_ff, count_in;
   fra_pkg::word_type mean_ff;
   fra_pkg::word_type frames_ff, frames_in;
   logic [32:0]       window_ff, window_in;
   fra_pkg::word_type rate_ff, rate_in;
   logic              upd_ff, upd_in;
   logic              rsp_valid_ff;
   fra_pkg::word_type rsp_mean_ff;
   fra_pkg::word_type rsp_rate_ff;
   logic              rsp_upd_ff;

   fra_pkg::word_type iv;
   fra_pkg::word_type diff;
   logic              store;
   logic              full;
   logic [32:0]       window_sum;
   fra_pkg::word_type chain [SAMPLES+1];
   logic              div_start;
   logic              div_done;
   fra_pkg::word_type div_q;
   logic              slot_free;
   logic              accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // interval, outlier check and window update
   always_comb begin
      iv         = now_ff - last_ff;
      diff       = (iv >= mean_ff) ? (iv - mean_ff) : (mean_ff - iv);
      store      = (diff < tps_ff);
      full       = (count_ff == FULL);
      sum_in     = sum_ff;
      count_in   = count_ff;
      if (store) begin
         sum_in = sum_ff + SW'(iv)
                  - (full ? SW'(chain[SAMPLES]) : SW'(0));
         if (!full) begin
            count_in = count_ff + 1'b1;
         end
      end
      frames_in  = (frames_ff == fra_pkg::WORD_MAX) ? frames_ff : frames_ff + 1'b1;
      window_sum = window_ff + {1'b0, iv};
      window_in  = window_sum;
      rate_in    = rate_ff;
      upd_in     = 1'b0;
      if (window_sum > {1'b0, tps_ff}) begin
         rate_in   = frames_in;
         frames_in = '0;
         window_in = '0;
         upd_in    = 1'b1;
      end
   end

   assign div_start = (state_ff == S_CALC);

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_CALC;
         S_CALC: state_in = S_DIV;
         S_DIV:  if (div_done) state_in = slot_free ? S_IDLE : S_HOLD;
         S_HOLD: if (slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tps_ff       <= fra_pkg::TPS_RESET;
         last_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         mean_ff      <= '0;
         frames_ff    <= '0;
         window_ff    <= '0;
         rate_ff      <= '0;
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            tps_ff <= csr_ticks_per_second;
         end
         if (state_ff == S_CALC) begin
            last_ff   <= now_ff;
            sum_ff    <= sum_in;
            count_ff  <= count_in;
            frames_ff <= frames_in;
            window_ff <= window_in;
            rate_ff   <= rate_in;
            upd_ff    <= upd_in;
         end
         if (div_done) begin
            mean_ff <= div_q;
         end
         if (((state_ff == S_DIV && div_done) || state_ff == S_HOLD) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff <= req_now;
      end
      if (state_ff == S_DIV && div_done && slot_free) begin
         rsp_mean_ff <= div_q;
         rsp_rate_ff <= rate_ff;
         rsp_upd_ff  <= upd_ff;
      end else if (state_ff == S_HOLD && slot_free) begin
         rsp_mean_ff <= mean_ff;
         rsp_rate_ff <= rate_ff;
         rsp_upd_ff  <= upd_ff;
      end
   end

   // history chain, newest interval enters at the head
   assign chain[0] = iv;

   for (genvar i = 0; i < SAMPLES; i++) begin : g_cell
      fra_cell u_cell (
         .clock    (clock),
         .shift_en (div_start && store),
         .d_in     (chain[i]),
         .d_out    (chain[i+1])
      );
   end

   // mean of the history
   fra_divider #(
      .SW (SW),
      .CW (CW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (count_in),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_average_interval = rsp_mean_ff;
   assign rsp_frame_rate       = rsp_rate_ff;
   assign rsp_rate_updated     = rsp_upd_ff;

endmodule
